// ===== hdl/bptc_pkg.sv =====
// bptc_pkg: widths, constants and register indexes for the barometer
// temperature compensation pipeline and its checker.
// No dependencies.
package bptc_pkg;

  // field and calibration widths
  localparam int RAW_W         = 24;
  localparam int CAL_W         = 16;
  localparam int TEMP_W        = 19;
  localparam int PA_W          = 27;
  localparam int CFG_ADDR_W    = 3;
  localparam int IN_TDATA_W    = 48;
  localparam int OUT_PAYLOAD_W = 73;
  localparam int OUT_TDATA_W   = 80;

  // internal datapath widths
  localparam int DT_W      = 25;   // d2 - c5*256
  localparam int MT_W      = 42;   // dt times a 16-bit coefficient
  localparam int DD_W      = 50;   // dt squared
  localparam int ACC_W     = 48;   // offset, sensitivity and correction terms
  localparam int SQ_W      = 38;   // square of a temperature delta
  localparam int SPLIT_W   = 24;   // low slice of sens for the split product
  localparam int PP_LO_W   = 48;
  localparam int PP_HI_W   = 49;
  localparam int PROD_W    = 64;
  localparam int RECIP_W   = 32;
  localparam int QM_W      = 59;
  localparam int A25_W     = 39;

  localparam int NUM_STAGES = 13;

  localparam logic signed [TEMP_W-1:0] TEMP_REF    = 19'sd2000;
  // temp + 1500 expressed from the delta to 2000
  localparam logic signed [TEMP_W-1:0] TEMP_DV_OFS = 19'sd3500;

  localparam logic [11:0] MMHG_MUL = 12'd2500;
  localparam logic [11:0] MMHG_DIV = 12'd3333;
  // floor(2^32 * 2500 / 3333), quotient estimate is exact or one low
  localparam logic [RECIP_W-1:0] MMHG_RECIP = RECIP_W'((64'd2500 << 32) / 64'd3333);

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_PRESSURE_SENS  = 3'd0,
    REG_PRESSURE_OFS   = 3'd1,
    REG_SENS_TEMP_COEF = 3'd2,
    REG_OFS_TEMP_COEF  = 3'd3,
    REG_REF_TEMP       = 3'd4,
    REG_TEMP_COEF      = 3'd5
  } cfg_reg_t;

endpackage

// ===== hdl/baro_pressure_temp_compensation_unit.sv =====
// throughput: one item per cycle while in_tready is high; each stage has its own valid bit, so empty stages
// fill while a result waits and in_tready drops only when all 13 stages hold items
// the deepest logic is the 27x32 reciprocal multiply and the split 24x48 product
// reset (rst_n low, synchronous) empties the pipeline and clears the calibration words
// baro_pressure_temp_compensation_unit: pipelined second-order compensation
// depends on bptc_pkg
module baro_pressure_temp_compensation_unit
  import bptc_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_we,
  input  logic [CFG_ADDR_W-1:0]  cfg_addr,
  input  logic [CAL_W-1:0]       cfg_wdata,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // raw_pressure[23:0], raw_temperature[47:24]
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata   // temp_centi_c[18:0], pressure_pa[45:19],
                                             // pressure_centi_mmhg[72:46], zeros above
);

  // calibration words
  logic [CAL_W-1:0] pressure_sensitivity_r, pressure_offset_r, sens_temp_coeff_r;
  logic [CAL_W-1:0] offset_temp_coeff_r, reference_temperature_r, temperature_coeff_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pressure_sensitivity_r  <= '0;
      pressure_offset_r       <= '0;
      sens_temp_coeff_r       <= '0;
      offset_temp_coeff_r     <= '0;
      reference_temperature_r <= '0;
      temperature_coeff_r     <= '0;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_addr))
        REG_PRESSURE_SENS:  pressure_sensitivity_r  <= cfg_wdata;
        REG_PRESSURE_OFS:   pressure_offset_r       <= cfg_wdata;
        REG_SENS_TEMP_COEF: sens_temp_coeff_r       <= cfg_wdata;
        REG_OFS_TEMP_COEF:  offset_temp_coeff_r     <= cfg_wdata;
        REG_REF_TEMP:       reference_temperature_r <= cfg_wdata;
        REG_TEMP_COEF:      temperature_coeff_r     <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // pipeline control: a stage loads when it is empty or its content moves on
  logic [NUM_STAGES-1:0] v_r, v_nxt, ld, vin;

  always_comb begin
    ld[NUM_STAGES-1] = !v_r[NUM_STAGES-1] || out_tready;
    for (int s = NUM_STAGES - 2; s >= 0; s--) begin
      ld[s] = !v_r[s] || ld[s+1];
    end
  end

  assign vin       = {v_r[NUM_STAGES-2:0], in_tvalid};
  assign v_nxt     = (ld & vin) | (~ld & v_r);
  assign in_tready = ld[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= v_nxt;
    end
  end

  // stage 0: temperature difference
  logic [RAW_W-1:0]        raw_p, raw_t;
  logic [RAW_W-1:0]        d1_s0_r;
  logic signed [DT_W-1:0]  dt_nxt, dt_s0_r;

  assign raw_p  = in_tdata[RAW_W-1:0];
  assign raw_t  = in_tdata[2*RAW_W-1:RAW_W];
  assign dt_nxt = $signed({1'b0, raw_t}) - $signed({1'b0, reference_temperature_r, 8'b0});

  // stage 1: first-order products
  logic [RAW_W-1:0]        d1_s1_r;
  logic signed [MT_W-1:0]  mt_nxt, mo_nxt, ms_nxt, mt_s1_r, mo_s1_r, ms_s1_r;
  logic signed [DD_W-1:0]  dd_nxt, dd_s1_r;

  assign mt_nxt = dt_s0_r * $signed({1'b0, temperature_coeff_r});
  assign mo_nxt = dt_s0_r * $signed({1'b0, offset_temp_coeff_r});
  assign ms_nxt = dt_s0_r * $signed({1'b0, sens_temp_coeff_r});
  assign dd_nxt = dt_s0_r * dt_s0_r;

  // stage 2: temperature, offset, sensitivity
  logic [RAW_W-1:0]         d1_s2_r;
  logic signed [TEMP_W-1:0] dl_nxt, dv_nxt, temp1_nxt, t2_nxt;
  logic signed [TEMP_W-1:0] dl_s2_r, dv_s2_r, temp1_s2_r, t2_s2_r;
  logic signed [ACC_W-1:0]  off1_nxt, sens1_nxt, off1_s2_r, sens1_s2_r;

  assign dl_nxt    = mt_s1_r[MT_W-1:23];          // dt*c6 >>> 23 = temp - 2000
  assign temp1_nxt = dl_nxt + TEMP_REF;
  assign dv_nxt    = dl_nxt + TEMP_DV_OFS;        // temp + 1500
  assign t2_nxt    = dd_s1_r[DD_W-1:31];          // dt^2 >>> 31, never negative
  assign off1_nxt  = $signed({16'b0, pressure_offset_r, 16'b0}) + (ACC_W'(mo_s1_r) >>> 7);
  assign sens1_nxt = $signed({17'b0, pressure_sensitivity_r, 15'b0})
                   + (ACC_W'(ms_s1_r) >>> 8);

  // stage 3: squares of the deltas
  logic [RAW_W-1:0]         d1_s3_r;
  logic signed [TEMP_W-1:0] temp1_s3_r, t2_s3_r;
  logic                     low_s3_r, vlow_s3_r;
  logic signed [ACC_W-1:0]  off1_s3_r, sens1_s3_r;
  logic signed [SQ_W-1:0]   dl2_nxt, dv2_nxt, dl2_s3_r, dv2_s3_r;

  assign dl2_nxt = dl_s2_r * dl_s2_r;
  assign dv2_nxt = dv_s2_r * dv_s2_r;

  // stage 4: scaled correction terms
  logic [RAW_W-1:0]         d1_s4_r;
  logic signed [TEMP_W-1:0] temp1_s4_r, t2_s4_r;
  logic                     low_s4_r, vlow_s4_r;
  logic signed [ACC_W-1:0]  off1_s4_r, sens1_s4_r;
  logic signed [ACC_W-1:0]  a5_nxt, b7_nxt, c11_nxt, a5_s4_r, b7_s4_r, c11_s4_r;

  assign a5_nxt  = ACC_W'(dl2_s3_r) + (ACC_W'(dl2_s3_r) <<< 2);
  assign b7_nxt  = (ACC_W'(dv2_s3_r) <<< 3) - ACC_W'(dv2_s3_r);
  assign c11_nxt = (ACC_W'(dv2_s3_r) <<< 3) + (ACC_W'(dv2_s3_r) <<< 1) + ACC_W'(dv2_s3_r);

  // stage 5: apply the second-order correction
  logic [RAW_W-1:0]         d1_s5_r;
  logic signed [TEMP_W-1:0] temp_nxt, temp_s5_r;
  logic signed [ACC_W-1:0]  off2, sens2, off_nxt, sens_nxt, off_s5_r, sens_s5_r;

  // below -15 C implies below 20 C, so the extra terms only add to the first ones
  assign off2     = (a5_s4_r >>> 1) + (vlow_s4_r ? b7_s4_r : '0);
  assign sens2    = (a5_s4_r >>> 2) + (vlow_s4_r ? (c11_s4_r >>> 1) : '0);
  assign temp_nxt = low_s4_r ? temp1_s4_r - t2_s4_r : temp1_s4_r;
  assign off_nxt  = low_s4_r ? off1_s4_r - off2 : off1_s4_r;
  assign sens_nxt = low_s4_r ? sens1_s4_r - sens2 : sens1_s4_r;

  // stage 6: d1 * sens as two partial products
  logic signed [TEMP_W-1:0]  temp_s6_r;
  logic signed [ACC_W-1:0]   off_s6_r;
  logic [PP_LO_W-1:0]        pplo_nxt, pplo_s6_r;
  logic signed [PP_HI_W-1:0] pphi_nxt, pphi_s6_r;

  assign pplo_nxt = d1_s5_r * sens_s5_r[SPLIT_W-1:0];
  assign pphi_nxt = $signed({1'b0, d1_s5_r}) * $signed(sens_s5_r[ACC_W-1:SPLIT_W]);

  // stage 7: combine partial products
  logic signed [TEMP_W-1:0] temp_s7_r;
  logic signed [ACC_W-1:0]  off_s7_r;
  logic signed [PROD_W-1:0] prod_nxt, prod_s7_r;

  assign prod_nxt = (PROD_W'(pphi_s6_r) <<< SPLIT_W) + $signed({16'b0, pplo_s6_r});

  // stage 8: pressure in pa
  logic signed [TEMP_W-1:0] temp_s8_r;
  logic signed [ACC_W-1:0]  pdiff;
  logic signed [PA_W-1:0]   p_nxt, p_s8_r;

  assign pdiff = ACC_W'(prod_s7_r >>> 21) - off_s7_r;
  assign p_nxt = pdiff[PA_W+14:15];

  // stage 9: magnitude for the mmhg conversion
  logic signed [TEMP_W-1:0] temp_s9_r;
  logic signed [PA_W-1:0]   p_s9_r;
  logic [PA_W-1:0]          ap_nxt, ap_s9_r;
  logic                     neg_s9_r;

  assign ap_nxt = p_s8_r[PA_W-1] ? PA_W'(-p_s8_r) : p_s8_r;

  // stage 10: reciprocal multiply
  logic signed [TEMP_W-1:0] temp_s10_r;
  logic signed [PA_W-1:0]   p_s10_r;
  logic [PA_W-1:0]          ap_s10_r;
  logic                     neg_s10_r;
  logic [QM_W-1:0]          qm_nxt, qm_s10_r;

  assign qm_nxt = QM_W'(ap_s9_r) * QM_W'(MMHG_RECIP);

  // stage 11: quotient estimate and remainder terms
  logic signed [TEMP_W-1:0] temp_s11_r;
  logic signed [PA_W-1:0]   p_s11_r;
  logic                     neg_s11_r;
  logic [PA_W-1:0]          q0_nxt, q0_s11_r;
  logic [A25_W-1:0]         q3_nxt, a25_nxt, q3_s11_r, a25_s11_r;

  assign q0_nxt  = qm_s10_r[QM_W-1:RECIP_W];
  assign q3_nxt  = A25_W'(q0_nxt) * A25_W'(MMHG_DIV);
  assign a25_nxt = A25_W'(ap_s10_r) * A25_W'(MMHG_MUL);

  // stage 12: correct the estimate, restore sign, output register
  logic signed [TEMP_W-1:0] temp_s12_r;
  logic signed [PA_W-1:0]   p_s12_r;
  logic [A25_W-1:0]         rem;
  logic [PA_W-1:0]          q;
  logic signed [PA_W-1:0]   mm_nxt, mm_s12_r;

  assign rem    = a25_s11_r - q3_s11_r;
  assign q      = q0_s11_r + PA_W'(rem >= A25_W'(MMHG_DIV));
  assign mm_nxt = neg_s11_r ? PA_W'(-$signed(q)) : $signed(q);

  always_ff @(posedge clk) begin
    if (ld[0]) begin
      d1_s0_r <= raw_p;
      dt_s0_r <= dt_nxt;
    end
    if (ld[1]) begin
      d1_s1_r <= d1_s0_r;
      mt_s1_r <= mt_nxt;
      mo_s1_r <= mo_nxt;
      ms_s1_r <= ms_nxt;
      dd_s1_r <= dd_nxt;
    end
    if (ld[2]) begin
      d1_s2_r    <= d1_s1_r;
      dl_s2_r    <= dl_nxt;
      dv_s2_r    <= dv_nxt;
      temp1_s2_r <= temp1_nxt;
      t2_s2_r    <= t2_nxt;
      off1_s2_r  <= off1_nxt;
      sens1_s2_r <= sens1_nxt;
    end
    if (ld[3]) begin
      d1_s3_r    <= d1_s2_r;
      temp1_s3_r <= temp1_s2_r;
      t2_s3_r    <= t2_s2_r;
      low_s3_r   <= dl_s2_r[TEMP_W-1];
      vlow_s3_r  <= dv_s2_r[TEMP_W-1];
      off1_s3_r  <= off1_s2_r;
      sens1_s3_r <= sens1_s2_r;
      dl2_s3_r   <= dl2_nxt;
      dv2_s3_r   <= dv2_nxt;
    end
    if (ld[4]) begin
      d1_s4_r    <= d1_s3_r;
      temp1_s4_r <= temp1_s3_r;
      t2_s4_r    <= t2_s3_r;
      low_s4_r   <= low_s3_r;
      vlow_s4_r  <= vlow_s3_r;
      off1_s4_r  <= off1_s3_r;
      sens1_s4_r <= sens1_s3_r;
      a5_s4_r    <= a5_nxt;
      b7_s4_r    <= b7_nxt;
      c11_s4_r   <= c11_nxt;
    end
    if (ld[5]) begin
      d1_s5_r   <= d1_s4_r;
      temp_s5_r <= temp_nxt;
      off_s5_r  <= off_nxt;
      sens_s5_r <= sens_nxt;
    end
    if (ld[6]) begin
      temp_s6_r <= temp_s5_r;
      off_s6_r  <= off_s5_r;
      pplo_s6_r <= pplo_nxt;
      pphi_s6_r <= pphi_nxt;
    end
    if (ld[7]) begin
      temp_s7_r <= temp_s6_r;
      off_s7_r  <= off_s6_r;
      prod_s7_r <= prod_nxt;
    end
    if (ld[8]) begin
      temp_s8_r <= temp_s7_r;
      p_s8_r    <= p_nxt;
    end
    if (ld[9]) begin
      temp_s9_r <= temp_s8_r;
      p_s9_r    <= p_s8_r;
      ap_s9_r   <= ap_nxt;
      neg_s9_r  <= p_s8_r[PA_W-1];
    end
    if (ld[10]) begin
      temp_s10_r <= temp_s9_r;
      p_s10_r    <= p_s9_r;
      ap_s10_r   <= ap_s9_r;
      neg_s10_r  <= neg_s9_r;
      qm_s10_r   <= qm_nxt;
    end
    if (ld[11]) begin
      temp_s11_r <= temp_s10_r;
      p_s11_r    <= p_s10_r;
      neg_s11_r  <= neg_s10_r;
      q0_s11_r   <= q0_nxt;
      q3_s11_r   <= q3_nxt;
      a25_s11_r  <= a25_nxt;
    end
    if (ld[12]) begin
      temp_s12_r <= temp_s11_r;
      p_s12_r    <= p_s11_r;
      mm_s12_r   <= mm_nxt;
    end
  end

  assign out_tvalid = v_r[NUM_STAGES-1];
  assign out_tdata  = {{(OUT_TDATA_W-OUT_PAYLOAD_W){1'b0}}, mm_s12_r, p_s12_r, temp_s12_r};

endmodule

// ===== hdl/bptc_checker.sv =====
// bptc_port_checks: port-level assertions on the compensation pipeline, bound to the top level
// depends on bptc_pkg and baro_pressure_temp_compensation_unit
module bptc_port_checks
  import bptc_pkg::*;
(
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_tvalid,
  input logic                   in_tready,
  input logic                   out_tvalid,
  input logic                   out_tready,
  input logic [OUT_TDATA_W-1:0] out_tdata
);

  localparam int OCC_W = $clog2(NUM_STAGES + 1);

  // items accepted whose results have not been taken yet
  logic [OCC_W-1:0] occ_r, occ_nxt;
  logic             in_acc, out_acc;

  assign in_acc  = in_tvalid && in_tready;
  assign out_acc = out_tvalid && out_tready;
  assign occ_nxt = occ_r + OCC_W'(in_acc) - OCC_W'(out_acc);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r <= '0;
    end else begin
      occ_r <= occ_nxt;
    end
  end

  a_no_invented_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> occ_r != '0)
    else $error("result shown with no item in flight");

  a_depth_bound: assert property (@(posedge clk) disable iff (!rst_n)
    occ_r <= OCC_W'(NUM_STAGES))
    else $error("more items in flight than pipeline stages");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    occ_r == '0 |-> in_tready)
    else $error("input stalled while pipeline is empty");

  a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result changed or dropped");

  a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[OUT_TDATA_W-1:OUT_PAYLOAD_W] == '0)
    else $error("padding bits of out_tdata not zero");

endmodule

bind baro_pressure_temp_compensation_unit bptc_port_checks u_bptc_port_checks (.*);
